// ===== design/lpsc_pkg.sv =====
package lpsc_pkg;

  localparam int unsigned PixelWidth = 32;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned CountWidth = 33;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned HeaderPixels = 4;

  // Low-bit masks of each color plane (keep the upper bits).
  localparam logic [7:0] RedKeepMask   = 8'hF8;
  localparam logic [7:0] GreenKeepMask = 8'hFC;
  localparam logic [7:0] BlueKeepMask  = 8'hF8;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_EXTRACT_MODE   = 2'd0,
    CFG_USE_XOR        = 2'd1,
    CFG_PAYLOAD_LENGTH = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic        extract_mode;
    logic        use_xor;
    logic [31:0] payload_length;
  } cfg_t;

  typedef struct packed {
    logic        frame_start;
    logic [31:0] pixel_in;
    logic [31:0] ref_pixel;
    logic [7:0]  payload_byte;
  } in_item_t;

  // Spread one byte over a pixel: bits 7:5 into red, 4:3 into green, 2:0 into blue.
  function automatic logic [31:0] merge_byte(input logic [31:0] px, input logic [7:0] b,
                                             input logic xr);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] bl;
    r  = px[7:0];
    g  = px[15:8];
    bl = px[23:16];
    if (xr) begin
      r  = r ^ {5'd0, b[7:5]};
      g  = g ^ {6'd0, b[4:3]};
      bl = bl ^ {5'd0, b[2:0]};
    end else begin
      r  = (r & RedKeepMask) | {5'd0, b[7:5]};
      g  = (g & GreenKeepMask) | {6'd0, b[4:3]};
      bl = (bl & BlueKeepMask) | {5'd0, b[2:0]};
    end
    return {px[31:24], bl, g, r};
  endfunction

  function automatic logic [7:0] read_byte(input logic [31:0] px);
    return {px[2:0], px[9:8], px[18:16]};
  endfunction

endpackage

// ===== design/lpsc_in_if.sv =====
interface lpsc_in_if;
  logic        valid;
  logic        ready;
  logic        frame_start;
  logic [31:0] pixel_in;
  logic [31:0] ref_pixel;
  logic [7:0]  payload_byte;

  modport source (output valid, frame_start, pixel_in, ref_pixel, payload_byte,
                  input ready);
  modport sink (input valid, frame_start, pixel_in, ref_pixel, payload_byte,
                output ready);
endinterface

// ===== design/lpsc_out_if.sv =====
interface lpsc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;
  logic        payload_taken;
  logic [7:0]  byte_out;
  logic        byte_valid;
  logic        last_byte;
  logic        payload_done;

  modport source (output valid, pixel_out, payload_taken, byte_out, byte_valid,
                  last_byte, payload_done, input ready);
  modport sink (input valid, pixel_out, payload_taken, byte_out, byte_valid,
                last_byte, payload_done, output ready);
endinterface

// ===== design/lpsc_cfg_if.sv =====
interface lpsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/lpsc_cfg_regs.sv =====
module lpsc_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  lpsc_cfg_if.sink      cfg,
  output lpsc_pkg::cfg_t cfg_o
);
  import lpsc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg.ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg.valid) begin
      case (cfg.index)
        CFG_EXTRACT_MODE:   cfg_nxt.extract_mode   = cfg.data[0];
        CFG_USE_XOR:        cfg_nxt.use_xor        = cfg.data[0];
        CFG_PAYLOAD_LENGTH: cfg_nxt.payload_length = cfg.data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end
endmodule

// ===== design/lpsc_in_stage.sv =====
module lpsc_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  lpsc_in_if.sink            in_s,
  output logic               item_valid,
  output lpsc_pkg::in_item_t item,
  input  logic               item_take
);
  import lpsc_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     load;

  // The register refills in the same cycle its item moves on.
  assign in_s.ready = !valid_r || item_take;
  assign load       = in_s.valid && in_s.ready;
  assign valid_nxt  = load || (valid_r && !item_take);
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= '{frame_start: in_s.frame_start, pixel_in: in_s.pixel_in,
                  ref_pixel: in_s.ref_pixel, payload_byte: in_s.payload_byte};
    end
  end
endmodule

// ===== design/lpsc_engine.sv =====
module lpsc_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  lpsc_pkg::cfg_t     cfg_i,
  input  logic               item_valid,
  input  lpsc_pkg::in_item_t item,
  output logic               item_take,
  lpsc_out_if.source         out_s
);
  import lpsc_pkg::*;

  logic [CountWidth-1:0] count_r, count_nxt;
  logic [31:0]           dlen_r, dlen_nxt;
  logic                  fin_r, fin_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] pix_r, pix_nxt;
  logic        taken_r, taken_nxt;
  logic [7:0]  bout_r, bout_nxt;
  logic        bvalid_r, bvalid_nxt;
  logic        last_r, last_nxt;
  logic        done_r;

  logic [CountWidth-1:0] p;
  logic [31:0]           dl;
  logic                  fin;
  logic                  in_header;
  logic [1:0]            hidx;
  logic [7:0]            hdr_byte;
  logic [CountWidth-1:0] len_ext;
  logic [CountWidth-1:0] dlen_ext;
  logic [31:0]           src;
  logic [7:0]            rb;
  logic [31:0]           rb_shift;

  assign item_take = item_valid && (!out_valid_r || out_s.ready);

  always_comb begin
    // A frame start clears the state before this pixel is handled.
    p         = item.frame_start ? '0 : count_r;
    dl        = item.frame_start ? '0 : dlen_r;
    fin       = item.frame_start ? 1'b0 : fin_r;
    in_header = (p[CountWidth-1:2] == '0);
    hidx      = p[1:0];
    len_ext   = {1'b0, cfg_i.payload_length};
    src       = cfg_i.use_xor ? (item.pixel_in ^ item.ref_pixel) : item.pixel_in;
    rb        = read_byte(src);

    case (hidx)
      2'd0:    hdr_byte = cfg_i.payload_length[7:0];
      2'd1:    hdr_byte = cfg_i.payload_length[15:8];
      2'd2:    hdr_byte = cfg_i.payload_length[23:16];
      default: hdr_byte = cfg_i.payload_length[31:24];
    endcase

    case (hidx)
      2'd0:    rb_shift = {24'd0, rb};
      2'd1:    rb_shift = {16'd0, rb, 8'd0};
      2'd2:    rb_shift = {8'd0, rb, 16'd0};
      default: rb_shift = {rb, 24'd0};
    endcase

    pix_nxt    = item.pixel_in;
    taken_nxt  = 1'b0;
    bout_nxt   = '0;
    bvalid_nxt = 1'b0;
    last_nxt   = 1'b0;
    dlen_nxt   = dl;
    fin_nxt    = fin;
    dlen_ext   = {1'b0, dl};

    if (!cfg_i.extract_mode) begin
      if (in_header) begin
        pix_nxt = merge_byte(item.pixel_in, hdr_byte, cfg_i.use_xor);
        if (hidx == 2'd3 && cfg_i.payload_length == '0) begin
          fin_nxt = 1'b1;
        end
      end else if (p < len_ext + CountWidth'(HeaderPixels)) begin
        pix_nxt   = merge_byte(item.pixel_in, item.payload_byte, cfg_i.use_xor);
        taken_nxt = 1'b1;
        if (p == len_ext + CountWidth'(HeaderPixels - 1)) begin
          last_nxt = 1'b1;
          fin_nxt  = 1'b1;
        end
      end
    end else begin
      if (in_header) begin
        dlen_nxt = dl | rb_shift;
        if (hidx == 2'd3 && dlen_nxt == '0) begin
          fin_nxt = 1'b1;
        end
      end else if (!fin && p < dlen_ext + CountWidth'(HeaderPixels)) begin
        bout_nxt   = rb;
        bvalid_nxt = 1'b1;
        if (p == dlen_ext + CountWidth'(HeaderPixels - 1)) begin
          last_nxt = 1'b1;
          fin_nxt  = 1'b1;
        end
      end
    end

    // The pixel index saturates at its all-ones value.
    count_nxt     = (&p) ? p : p + CountWidth'(1);
    out_valid_nxt = item_take || (out_valid_r && !out_s.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dlen_r      <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (item_take) begin
        count_r <= count_nxt;
        dlen_r  <= dlen_nxt;
        fin_r   <= fin_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      pix_r    <= pix_nxt;
      taken_r  <= taken_nxt;
      bout_r   <= bout_nxt;
      bvalid_r <= bvalid_nxt;
      last_r   <= last_nxt;
      done_r   <= fin_nxt;
    end
  end

  assign out_s.valid         = out_valid_r;
  assign out_s.pixel_out     = pix_r;
  assign out_s.payload_taken = taken_r;
  assign out_s.byte_out      = bout_r;
  assign out_s.byte_valid    = bvalid_r;
  assign out_s.last_byte     = last_r;
  assign out_s.payload_done  = done_r;
endmodule

// ===== design/lsb_pixel_stego_codec_core.sv =====
// Channel     | Dir | Handshake       | Payload
// in_stream   | in  | valid / ready   | frame_start, pixel_in, ref_pixel, payload_byte
// out_stream  | out | valid / ready   | pixel_out, payload_taken, byte_out, byte_valid,
//             |     |                 | last_byte, payload_done
// cfg_port    | in  | valid / ready   | index (2 bits), data (32 bits)
//
// Each pixel passes from input transfer to result through two registers: the input register,
// then the merge/extract logic into the result register. One pixel is accepted per cycle while
// the result is not stalled; the rate is set by the single per-pixel state update (pixel index,
// decoded length and finished flag). Reset (rst_n low, synchronous) clears the configuration
// registers, the frame state and both valid flags. A stalled result holds in its register while
// an empty input register still takes one more pixel; the configuration port always accepts.
module lsb_pixel_stego_codec_core (
  input  logic        clk,
  input  logic        rst_n,
  lpsc_in_if.sink     in_stream,
  lpsc_out_if.source  out_stream,
  lpsc_cfg_if.sink    cfg_port
);
  import lpsc_pkg::*;

  cfg_t     cfg;
  logic     item_valid;
  in_item_t item;
  logic     item_take;

  // Configuration registers: mode, XOR select and embed payload length.
  lpsc_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_port),
    .cfg_o (cfg)
  );

  // Input register; it refills in the same cycle its pixel moves to the engine.
  lpsc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_s       (in_stream),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // Header and payload merge or extraction, frame state and result register.
  lpsc_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_s      (out_stream)
  );
endmodule
